/* hdl/h2r_pkg.sv */
package h2r_pkg;

   localparam logic [12:0] UNIT_FRAC  = 13'd4096;
   localparam logic [13:0] TWO_UNIT   = 14'd4096;
   localparam logic [14:0] HUE_SECTOR = 15'd3840;
   localparam logic [14:0] HUE_PERIOD = 15'd7680;
   localparam logic [14:0] HUE_FULL   = 15'd23040;
   localparam logic [11:0] SECTOR_K   = 12'd3840;
   localparam logic [9:0]  CHAN_MAX   = 10'd255;

   localparam int CHROMA_W = 25;
   localparam int PART_W   = 36;
   localparam int SUM_W    = 37;
   localparam int SCALE_W  = 42;

   typedef logic [2:0] sector_type;

   localparam sector_type SEC_RED_YEL = 3'd0;
   localparam sector_type SEC_YEL_GRN = 3'd1;
   localparam sector_type SEC_GRN_CYN = 3'd2;
   localparam sector_type SEC_CYN_BLU = 3'd3;
   localparam sector_type SEC_BLU_MAG = 3'd4;
   localparam sector_type SEC_MAG_RED = 3'd5;
   localparam sector_type SEC_NONE    = 3'd6;

   typedef enum logic [1:0] {
      PICK_ZERO,
      PICK_C,
      PICK_X
   } pick_type;

endpackage

/* hdl/hsl_to_rgb_converter.sv */
// Channel   Handshake           Payload
// request   start / busy        req_hue[14:0], req_saturation[12:0], req_lightness[12:0]
// response  rsp_valid strobe    rsp_red[7:0], rsp_green[7:0], rsp_blue[7:0]
//
// Five register stages; one item per clock outside reset. An item taken with start
// moves through the stage registers in order and is strobed from the last. The stages
// are sector and hue fold, chroma multiply, second-factor multiply, channel sum,
// and scale with clamp.
// busy is high only during reset; the receiver takes every strobed result, so
// nothing stalls. Reset clears the valid bits only; payload registers are not reset.
module hsl_to_rgb_converter import h2r_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [14:0] req_hue,
   input  logic [12:0] req_saturation,
   input  logic [12:0] req_lightness,
   output logic        rsp_valid,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue
);

   logic [4:0] valid_ff, valid_in;

   // stage 1
   logic [12:0] sat_c, lit_c, lit_dist, fac_in, fac_ff, sat_ff, lit1_ff;
   logic [13:0] twol;
   logic [14:0] hue_t;
   logic [12:0] tdist;
   logic [11:0] kx_in, kx1_ff, kx2_ff;
   sector_type  sec_in, sec1_ff, sec2_ff, sec3_ff;

   // stage 2
   logic [CHROMA_W-1:0] c24_in, c24_ff;
   logic [12:0]         lit2_ff;

   // stage 3
   logic [PART_W-1:0] xd_in, xd_ff, cd_in, cd_ff, md_in, md_ff;
   logic [25:0]       lfull, m2;

   // stage 4
   logic [SUM_W-1:0] nr_in, ng_in, nb_in, nr_ff, ng_ff, nb_ff;
   pick_type         pr, pg, pb;

   // stage 5
   logic [7:0] red_in, green_in, blue_in, red_ff, green_ff, blue_ff;

   assign busy = reset;

   always_comb begin
      sat_c = (req_saturation > UNIT_FRAC) ? UNIT_FRAC : req_saturation;
      lit_c = (req_lightness > UNIT_FRAC) ? UNIT_FRAC : req_lightness;
      twol  = {lit_c, 1'b0};
      lit_dist = (twol >= TWO_UNIT) ? 13'(twol - TWO_UNIT) : 13'(TWO_UNIT - twol);
      fac_in = UNIT_FRAC - lit_dist;

      if (req_hue >= 15'(4 * HUE_PERIOD)) begin
         hue_t = req_hue - 15'(4 * HUE_PERIOD);
      end else if (req_hue >= 15'(3 * HUE_PERIOD)) begin
         hue_t = req_hue - 15'(3 * HUE_PERIOD);
      end else if (req_hue >= 15'(2 * HUE_PERIOD)) begin
         hue_t = req_hue - 15'(2 * HUE_PERIOD);
      end else if (req_hue >= HUE_PERIOD) begin
         hue_t = req_hue - HUE_PERIOD;
      end else begin
         hue_t = req_hue;
      end
      tdist = (hue_t >= HUE_SECTOR) ? 13'(hue_t - HUE_SECTOR) : 13'(HUE_SECTOR - hue_t);
      kx_in = 12'(13'(SECTOR_K) - tdist);

      if (req_hue <= HUE_SECTOR) begin
         sec_in = SEC_RED_YEL;
      end else if (req_hue <= 15'(2 * HUE_SECTOR)) begin
         sec_in = SEC_YEL_GRN;
      end else if (req_hue <= 15'(3 * HUE_SECTOR)) begin
         sec_in = SEC_GRN_CYN;
      end else if (req_hue <= 15'(4 * HUE_SECTOR)) begin
         sec_in = SEC_CYN_BLU;
      end else if (req_hue <= 15'(5 * HUE_SECTOR)) begin
         sec_in = SEC_BLU_MAG;
      end else if (req_hue <= HUE_FULL) begin
         sec_in = SEC_MAG_RED;
      end else begin
         sec_in = SEC_NONE;
      end
   end

   assign c24_in = CHROMA_W'(fac_ff) * CHROMA_W'(sat_ff);

   always_comb begin
      xd_in = PART_W'(c24_ff) * PART_W'(kx2_ff);
      cd_in = (PART_W'(c24_ff) << 12) - (PART_W'(c24_ff) << 8);
      lfull = {lit2_ff, 13'd0};
      m2    = (lfull >= 26'(c24_ff)) ? (lfull - 26'(c24_ff)) : 26'd0;
      md_in = (PART_W'(m2) << 11) - (PART_W'(m2) << 7);
   end

   function automatic logic [PART_W-1:0] pick_part(input pick_type p,
                                                   input logic [PART_W-1:0] c,
                                                   input logic [PART_W-1:0] x);
      case (p)
         PICK_C:  pick_part = c;
         PICK_X:  pick_part = x;
         default: pick_part = '0;
      endcase
   endfunction

   always_comb begin
      unique case (sec3_ff)
         SEC_RED_YEL: begin pr = PICK_C;    pg = PICK_X;    pb = PICK_ZERO; end
         SEC_YEL_GRN: begin pr = PICK_X;    pg = PICK_C;    pb = PICK_ZERO; end
         SEC_GRN_CYN: begin pr = PICK_ZERO; pg = PICK_C;    pb = PICK_X;    end
         SEC_CYN_BLU: begin pr = PICK_ZERO; pg = PICK_X;    pb = PICK_C;    end
         SEC_BLU_MAG: begin pr = PICK_X;    pg = PICK_ZERO; pb = PICK_C;    end
         SEC_MAG_RED: begin pr = PICK_C;    pg = PICK_ZERO; pb = PICK_X;    end
         default:     begin pr = PICK_ZERO; pg = PICK_ZERO; pb = PICK_ZERO; end
      endcase
      nr_in = SUM_W'(md_ff) + SUM_W'(pick_part(pr, cd_ff, xd_ff));
      ng_in = SUM_W'(md_ff) + SUM_W'(pick_part(pg, cd_ff, xd_ff));
      nb_in = SUM_W'(md_ff) + SUM_W'(pick_part(pb, cd_ff, xd_ff));
   end

   // channel = floor(num * 17 / 2^32), clamp to 255
   function automatic logic [7:0] to_channel(input logic [SUM_W-1:0] num);
      logic [SCALE_W-1:0] prod;
      logic [9:0]         v;
      prod = (SCALE_W'(num) << 4) + SCALE_W'(num);
      v    = prod[SCALE_W-1:32];
      to_channel = (v > CHAN_MAX) ? 8'(CHAN_MAX) : v[7:0];
   endfunction

   always_comb begin
      red_in   = to_channel(nr_ff);
      green_in = to_channel(ng_ff);
      blue_in  = to_channel(nb_ff);
      valid_in = {valid_ff[3:0], start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fac_ff   <= fac_in;
      sat_ff   <= sat_c;
      lit1_ff  <= lit_c;
      kx1_ff   <= kx_in;
      sec1_ff  <= sec_in;

      c24_ff   <= c24_in;
      lit2_ff  <= lit1_ff;
      kx2_ff   <= kx1_ff;
      sec2_ff  <= sec1_ff;

      xd_ff    <= xd_in;
      cd_ff    <= cd_in;
      md_ff    <= md_in;
      sec3_ff  <= sec2_ff;

      nr_ff    <= nr_in;
      ng_ff    <= ng_in;
      nb_ff    <= nb_in;

      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid = valid_ff[4];
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule
